// ===== rtl/serial_status_indicator_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Status indicator assertion macros
// Shared concurrent assertion helpers for the status indicator RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_STATUS_INDICATOR_CONTROLLER_DEFINES_SVH
`define SERIAL_STATUS_INDICATOR_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SSIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("status indicator assertion failed");
// Condition must never be true outside reset.
`define SSIC_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("status indicator forbidden condition seen");
`else
`define SSIC_ASSERT(label, clk, rst, prop)
`define SSIC_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== rtl/ssic_pkg.sv =====
// ----------------------------------------------------------------------------
// Status indicator package
// Types, constants and lookup functions shared by the status indicator RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssic_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int QDEPTH     = 4;
   localparam int QAW        = $clog2(QDEPTH);

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] CSR_FRAME_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_CHIRP_STEP     = 2'd1;
   localparam logic [1:0] CSR_ALARM_PERIOD   = 2'd2;

   localparam logic [15:0] FRAME_INTERVAL_RST = 16'd500;
   localparam logic [9:0]  CHIRP_STEP_RST     = 10'd80;
   localparam logic [9:0]  ALARM_PERIOD_RST   = 10'd700;

   localparam logic [9:0]  BEEP_LEN    = 10'd80;
   localparam logic [9:0]  BEEP2_START = 10'd160;
   localparam logic [9:0]  BEEP2_END   = 10'd240;
   localparam logic [10:0] ALARM_HZ    = 11'd880;
   localparam logic [12:0] CHIRP_MAX   = 13'd8191;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   localparam logic [63:0] WORD_IDLE     = {"idle", 32'h0};
   localparam logic [63:0] WORD_THINKING = "thinking";
   localparam logic [63:0] WORD_RUNNING  = {"running", 8'h0};
   localparam logic [63:0] WORD_SUCCESS  = {"success", 8'h0};
   localparam logic [63:0] WORD_ERROR    = {"error", 24'h0};
   localparam logic [63:0] WORD_KEY      = {"state", 24'h0};

   typedef enum logic [2:0] {
      STATUS_IDLE     = 3'd0,
      STATUS_THINKING = 3'd1,
      STATUS_RUNNING  = 3'd2,
      STATUS_SUCCESS  = 3'd3,
      STATUS_ERROR    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CLS_CHAR,
      CLS_EOL,
      CLS_OK,
      CLS_TICK,
      CLS_NOP
   } cls_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_SCAN1,
      BK_MID,
      BK_SCAN2,
      BK_DECIDE,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic [15:0] frame_interval;
      logic [9:0]  chirp_step;
      logic [9:0]  alarm_period;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status_code;
      logic [7:0]  red_level;
      logic [7:0]  green_level;
      logic [7:0]  blue_level;
      logic        tone_on;
      logic [10:0] tone_hz;
      logic        tone_soft;
      logic [6:0]  frame_index;
      logic        status_changed;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic [63:0] word_bits(input logic [2:0] w);
      logic [63:0] r;
      case (w)
         STATUS_IDLE:     r = WORD_IDLE;
         STATUS_THINKING: r = WORD_THINKING;
         STATUS_RUNNING:  r = WORD_RUNNING;
         STATUS_SUCCESS:  r = WORD_SUCCESS;
         STATUS_ERROR:    r = WORD_ERROR;
         default:         r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] word_len(input logic [2:0] w);
      logic [3:0] r;
      case (w)
         STATUS_IDLE:     r = 4'd4;
         STATUS_THINKING: r = 4'd8;
         STATUS_RUNNING:  r = 4'd7;
         STATUS_SUCCESS:  r = 4'd7;
         STATUS_ERROR:    r = 4'd5;
         default:         r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] char_at(input logic [63:0] w, input logic [2:0] j);
      return w[63 - 8 * j -: 8];
   endfunction

   function automatic logic [6:0] seq_len(input status_type s);
      logic [6:0] r;
      case (s)
         STATUS_IDLE:     r = 7'd70;
         STATUS_THINKING: r = 7'd15;
         STATUS_RUNNING:  r = 7'd65;
         STATUS_SUCCESS:  r = 7'd38;
         STATUS_ERROR:    r = 7'd20;
         default:         r = 7'd70;
      endcase
      return r;
   endfunction

   function automatic logic [23:0] led_rgb(input status_type s);
      logic [23:0] r;
      case (s)
         STATUS_IDLE:     r = {8'd0, 8'd0, 8'd0};
         STATUS_THINKING: r = {8'd0, 8'd0, 8'd255};
         STATUS_RUNNING:  r = {8'd255, 8'd180, 8'd0};
         STATUS_SUCCESS:  r = {8'd0, 8'd255, 8'd0};
         STATUS_ERROR:    r = {8'd255, 8'd0, 8'd0};
         default:         r = 24'd0;
      endcase
      return r;
   endfunction

   function automatic logic [10:0] note_hz(input logic [1:0] n);
      logic [10:0] r;
      case (n)
         2'd0:    r = 11'd660;
         2'd1:    r = 11'd880;
         2'd2:    r = 11'd1175;
         default: r = 11'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ssic_front.sv =====
// ----------------------------------------------------------------------------
// Status indicator front end
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "serial_status_indicator_controller_defines.svh"

module ssic_front import ssic_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_data_byte,
   output logic            q_valid,
   output entry_type       q_head,
   input  wire logic       q_pop
);

   entry_type          q_mem [QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       count_ff, count_in;
   logic               wr_en, rd_en;
   entry_type          new_entry;

   always_comb begin
      new_entry.data = req_data_byte;
      case (req_kind)
         KIND_BYTE: begin
            new_entry.cls = ((req_data_byte == CHAR_LF) || (req_data_byte == CHAR_CR))
                            ? CLS_EOL : CLS_CHAR;
         end
         KIND_OK:   new_entry.cls = CLS_OK;
         KIND_TICK: new_entry.cls = CLS_TICK;
         default:   new_entry.cls = CLS_NOP;
      endcase
   end

   assign full    = (count_ff == (QAW+1)'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = q_mem[rd_ptr_ff];
   assign wr_en   = push && !full;
   assign rd_en   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[wr_ptr_ff] <= new_entry;
      end
   end

   `SSIC_NEVER(a_count_range, clock, reset, count_ff > (QAW+1)'(QDEPTH))
   `SSIC_ASSERT(a_ptr_gap, clock, reset, (wr_ptr_ff - rd_ptr_ff) == count_ff[QAW-1:0])
   `SSIC_ASSERT(a_pop_empty, clock, reset, (q_pop && !q_valid) |=> $stable(rd_ptr_ff))

endmodule

`default_nettype wire

// ===== rtl/ssic_back.sv =====
// ----------------------------------------------------------------------------
// Status indicator back end
// Executes queued items: line buffer, command decode, timers and tones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "serial_status_indicator_controller_defines.svh"

module ssic_back import ssic_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       q_valid,
   input  wire entry_type  q_head,
   output logic            q_pop,
   output logic            empty,
   input  wire logic       pop,
   output rsp_type         rsp
);

   localparam logic [LINE_AW-1:0] LINE_LAST = LINE_AW'(LINE_DEPTH - 1);

   back_state_type      state_ff, state_in;
   entry_type           item_ff, item_in;

   logic [7:0]          line_mem [LINE_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we;
   logic                issue;

   logic [LINE_AW-1:0]  len_ff, len_in;
   logic [LINE_AW-1:0]  ptr_ff, ptr_in;
   logic [LINE_AW-1:0]  idx_d_ff;
   logic                vld_d_ff;
   logic                fnd_ff, fnd_in;
   logic [LINE_AW-1:0]  first_ff, first_in;
   logic                kw_ff, kw_in;
   logic                sec_fnd_ff, sec_fnd_in;
   logic [LINE_AW-1:0]  sec_ff, sec_in;
   logic [LINE_AW-1:0]  lo_ff, lo_in;
   logic [LINE_AW-1:0]  hi_ff, hi_in;
   logic [4:0]          match_ff, match_in;

   status_type          status_ff, status_in;
   logic [9:0]          phase_ff, phase_in;
   logic [15:0]         fe_ff, fe_in;
   logic [6:0]          fn_ff, fn_in;
   logic                chirp_ff, chirp_in;
   logic [12:0]         ce_ff, ce_in;
   logic                changed_ff, changed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Scratch values for the datapath.
   logic [LINE_AW-1:0]  rel;
   logic [LINE_AW-1:0]  span;
   logic [10:0]         phase_nxt;
   logic [16:0]         fe_nxt;
   logic [7:0]          fn_nxt;
   logic [9:0]          div;
   logic [2:0]          step;
   logic [23:0]         rgb;
   logic                found;
   status_type          code;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if ((item_ff.cls == CLS_EOL) && (len_ff != '0)) begin
               state_in = BK_SCAN1;
            end else begin
               state_in = BK_EMIT;
            end
         end
         BK_SCAN1: begin
            if ((ptr_ff == len_ff) && !vld_d_ff) begin
               state_in = BK_MID;
            end
         end
         BK_MID: begin
            state_in = fnd_ff ? BK_SCAN2 : BK_EMIT;
         end
         BK_SCAN2: begin
            if ((ptr_ff == hi_ff) && !vld_d_ff) begin
               state_in = BK_DECIDE;
            end
         end
         BK_DECIDE: state_in = BK_EMIT;
         BK_EMIT:   state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      q_pop  = (state_ff == BK_IDLE) && q_valid && !rsp_valid_ff;
      mem_we = (state_ff == BK_EXEC) && (item_ff.cls == CLS_CHAR) && (len_ff < LINE_LAST);
      issue  = ((state_ff == BK_SCAN1) && (ptr_ff != len_ff)) ||
               ((state_ff == BK_SCAN2) && (ptr_ff != hi_ff));
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      item_in    = item_ff;
      len_in     = len_ff;
      ptr_in     = issue ? ptr_ff + 1'b1 : ptr_ff;
      fnd_in     = fnd_ff;
      first_in   = first_ff;
      kw_in      = kw_ff;
      sec_fnd_in = sec_fnd_ff;
      sec_in     = sec_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      match_in   = match_ff;
      status_in  = status_ff;
      phase_in   = phase_ff;
      fe_in      = fe_ff;
      fn_in      = fn_ff;
      chirp_in   = chirp_ff;
      ce_in      = ce_ff;
      changed_in = changed_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in     = rsp_ff;
      rel        = '0;
      span       = hi_ff - lo_ff;
      phase_nxt  = {1'b0, phase_ff} + 11'd1;
      fe_nxt     = {1'b0, fe_ff} + 17'd1;
      fn_nxt     = {1'b0, fn_ff} + 8'd1;
      div        = (cfg.chirp_step == '0) ? 10'd1 : cfg.chirp_step;
      step       = 3'd0;
      rgb        = led_rgb(status_ff);
      found      = 1'b0;
      code       = STATUS_IDLE;

      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               item_in    = q_head;
               changed_in = 1'b0;
            end
         end
         BK_EXEC: begin
            case (item_ff.cls)
               CLS_CHAR: begin
                  len_in = (len_ff < LINE_LAST) ? len_ff + 1'b1 : '0;
               end
               CLS_EOL: begin
                  ptr_in     = '0;
                  fnd_in     = 1'b0;
                  kw_in      = 1'b0;
                  sec_fnd_in = 1'b0;
                  hi_in      = '0;
               end
               CLS_OK: begin
                  if (status_ff == STATUS_ERROR) begin
                     status_in  = STATUS_IDLE;
                     chirp_in   = 1'b0;
                     fn_in      = '0;
                     fe_in      = '0;
                     changed_in = 1'b1;
                  end
               end
               CLS_TICK: begin
                  phase_in = (phase_nxt >= {1'b0, cfg.alarm_period}) ? '0 : phase_nxt[9:0];
                  if (chirp_ff && (ce_ff < CHIRP_MAX)) begin
                     ce_in = ce_ff + 1'b1;
                  end
                  if (fe_nxt >= {1'b0, cfg.frame_interval}) begin
                     fe_in = '0;
                     fn_in = (fn_nxt >= {1'b0, seq_len(status_ff)}) ? '0 : fn_nxt[6:0];
                  end else begin
                     fe_in = fe_nxt[15:0];
                  end
               end
               default: begin
               end
            endcase
         end
         BK_SCAN1: begin
            // Finds the trimmed span and checks for the leading keyword.
            if (vld_d_ff) begin
               rel = idx_d_ff - first_ff;
               if (!is_blank(rd_data_ff)) begin
                  hi_in = idx_d_ff + 1'b1;
               end
               if (!fnd_ff) begin
                  if (!is_blank(rd_data_ff)) begin
                     fnd_in   = 1'b1;
                     first_in = idx_d_ff;
                     kw_in    = (rd_data_ff == char_at(WORD_KEY, 3'd0));
                  end
               end else if (rel < LINE_AW'(5)) begin
                  kw_in = kw_ff && (rd_data_ff == char_at(WORD_KEY, rel[2:0]));
               end else if (rel == LINE_AW'(5)) begin
                  kw_in = kw_ff && is_blank(rd_data_ff);
               end else if (!is_blank(rd_data_ff) && !sec_fnd_ff) begin
                  sec_fnd_in = 1'b1;
                  sec_in     = idx_d_ff;
               end
            end
         end
         BK_MID: begin
            if (fnd_ff) begin
               lo_in    = (kw_ff && sec_fnd_ff) ? sec_ff : first_ff;
               ptr_in   = (kw_ff && sec_fnd_ff) ? sec_ff : first_ff;
               match_in = '1;
            end else begin
               len_in = '0;
            end
         end
         BK_SCAN2: begin
            if (vld_d_ff) begin
               rel = idx_d_ff - lo_ff;
               for (int w = 0; w < 5; w++) begin
                  if ((rel >= LINE_AW'(word_len(3'(w)))) ||
                      (rd_data_ff != char_at(word_bits(3'(w)), rel[2:0]))) begin
                     match_in[w] = 1'b0;
                  end
               end
            end
         end
         BK_DECIDE: begin
            len_in = '0;
            for (int w = 4; w >= 0; w--) begin
               if (match_ff[w] && (span == LINE_AW'(word_len(3'(w))))) begin
                  found = 1'b1;
                  code  = status_type'(3'(w));
               end
            end
            if (found && (code != status_ff)) begin
               status_in  = code;
               chirp_in   = (code == STATUS_SUCCESS);
               if (code == STATUS_SUCCESS) begin
                  ce_in = '0;
               end
               fn_in      = '0;
               fe_in      = '0;
               changed_in = 1'b1;
            end
         end
         BK_EMIT: begin
            rsp_in.status_code    = status_ff;
            rsp_in.red_level      = rgb[23:16];
            rsp_in.green_level    = rgb[15:8];
            rsp_in.blue_level     = rgb[7:0];
            rsp_in.tone_on        = 1'b0;
            rsp_in.tone_hz        = '0;
            rsp_in.tone_soft      = 1'b0;
            rsp_in.frame_index    = fn_ff;
            rsp_in.status_changed = changed_ff;
            if ((status_ff == STATUS_ERROR) &&
                ((phase_ff < BEEP_LEN) ||
                 ((phase_ff >= BEEP2_START) && (phase_ff < BEEP2_END)))) begin
               rsp_in.tone_on   = 1'b1;
               rsp_in.tone_hz   = ALARM_HZ;
               rsp_in.tone_soft = 1'b1;
            end
            if (chirp_ff) begin
               // Chirp step is the count of step boundaries already passed.
               for (int k = 1; k <= 6; k++) begin
                  if (ce_ff >= 13'(div * 13'(k))) begin
                     step = step + 3'd1;
                  end
               end
               if (step >= 3'd6) begin
                  chirp_in = 1'b0;
               end else if (!step[0]) begin
                  rsp_in.tone_on   = 1'b1;
                  rsp_in.tone_hz   = note_hz(step[2:1]);
                  rsp_in.tone_soft = 1'b0;
               end
            end
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         len_ff       <= '0;
         status_ff    <= STATUS_IDLE;
         phase_ff     <= '0;
         fe_ff        <= '0;
         fn_ff        <= '0;
         chirp_ff     <= 1'b0;
         ce_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         vld_d_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         status_ff    <= status_in;
         phase_ff     <= phase_in;
         fe_ff        <= fe_in;
         fn_ff        <= fn_in;
         chirp_ff     <= chirp_in;
         ce_ff        <= ce_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_d_ff     <= issue;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      ptr_ff     <= ptr_in;
      idx_d_ff   <= ptr_ff;
      fnd_ff     <= fnd_in;
      first_ff   <= first_in;
      kw_ff      <= kw_in;
      sec_fnd_ff <= sec_fnd_in;
      sec_ff     <= sec_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      match_ff   <= match_in;
      changed_ff <= changed_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[len_ff] <= item_ff.data;
      end
      rd_data_ff <= line_mem[ptr_ff];
   end

   assign empty = !rsp_valid_ff;
   assign rsp   = rsp_ff;

   `SSIC_NEVER(a_emit_overwrite, clock, reset, (state_ff == BK_EMIT) && rsp_valid_ff)
   `SSIC_ASSERT(a_chirp_success, clock, reset, chirp_ff |-> (status_ff == STATUS_SUCCESS))
   `SSIC_ASSERT(a_line_len, clock, reset, len_ff <= LINE_LAST)
   `SSIC_ASSERT(a_pop_idle, clock, reset, q_pop |=> (state_ff == BK_EXEC))

endmodule

`default_nettype wire

// ===== rtl/serial_status_indicator_controller.sv =====
// ----------------------------------------------------------------------------
// Serial status indicator controller
// Turns serial status commands, button presses and ms ticks into LED/tone.
// ----------------------------------------------------------------------------
// Usage: items enter through push/full with req_kind (0 serial byte, 1 OK
// press, 2 millisecond tick) and req_data_byte. Every item yields exactly one
// result, presented on the rsp_ ports while empty is low and taken with pop.
// A four-entry input queue decouples the front end from the execution engine.
// The engine writes each result into a one-entry result register and starts
// the next item only once that result has been taken; while the consumer
// stalls, the input queue fills and full rises.
// Flow: a tick, button press or ordinary byte passes from the input queue
// through the item register and the emit state into the result register;
// the engine finishes one item before it takes the next. A line end reads
// the stored line once and, if it holds a non-blank character, the trimmed
// command once more, one character per cycle.
// Reset (synchronous, active high) empties both queues, clears the line, sets
// the status to idle with all timers at zero, and loads the default register
// values: 500 ms frame interval, 80 ms chirp step, 700 ms alarm period.
// Registers are to be written through csr_we/csr_index/csr_wdata only while
// no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_status_indicator_controller import ssic_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_status_code,
   output logic [7:0]       rsp_red_level,
   output logic [7:0]       rsp_green_level,
   output logic [7:0]       rsp_blue_level,
   output logic             rsp_tone_on,
   output logic [10:0]      rsp_tone_hz,
   output logic             rsp_tone_soft,
   output logic [6:0]       rsp_frame_index,
   output logic             rsp_status_changed,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   logic      q_pop;
   entry_type q_head;
   rsp_type   rsp;

   // Configuration registers; writes to an unused index are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_INTERVAL: cfg_in.frame_interval = csr_wdata;
            CSR_CHIRP_STEP:     cfg_in.chirp_step     = csr_wdata[9:0];
            CSR_ALARM_PERIOD:   cfg_in.alarm_period   = csr_wdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_interval <= FRAME_INTERVAL_RST;
         cfg_ff.chirp_step     <= CHIRP_STEP_RST;
         cfg_ff.alarm_period   <= ALARM_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classifies each item and queues it for the engine.
   ssic_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   // Back end: line buffer, decoder, timers and the result register.
   ssic_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_status_code    = rsp.status_code;
   assign rsp_red_level      = rsp.red_level;
   assign rsp_green_level    = rsp.green_level;
   assign rsp_blue_level     = rsp.blue_level;
   assign rsp_tone_on        = rsp.tone_on;
   assign rsp_tone_hz        = rsp.tone_hz;
   assign rsp_tone_soft      = rsp.tone_soft;
   assign rsp_frame_index    = rsp.frame_index;
   assign rsp_status_changed = rsp.status_changed;

endmodule

`default_nettype wire
